>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the zone trigger.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check on every rising edge, muted while reset is active.
`define ASSERT_RST(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_RST(label, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

>>> hw/rtl/tpz_pkg.sv
// Types and constants of the tracked-point zone trigger.
package tpz_pkg;

  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned BTN_W    = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned Q_DEPTH  = 2;
  localparam int unsigned Q_PTR_W  = 1;

  localparam logic [BTN_W-1:0] BTN_NONE = 3'd0;
  localparam logic [BTN_W-1:0] BTN_FIVE = 3'd5;
  localparam logic [BTN_W-1:0] BTN_SIX  = 3'd6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIVISIONS  = 3'd0,
    CFG_DEBOUNCE   = 3'd1,
    CFG_LEFT_X     = 3'd2,
    CFG_BTN_ROWS   = 3'd3,
    CFG_EXPR_ROWS  = 3'd4,
    CFG_LOWER_COLS = 3'd5,
    CFG_UPPER_COLS = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    MD_NONE     = 3'd0,
    MD_UNARMED  = 3'd1,
    MD_ARMED    = 3'd2,
    MD_DEBOUNCE = 3'd3,
    MD_EXPR     = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_BUTTON = 2'd1,
    EV_LEVEL  = 2'd2
  } ev_kind_e;

  typedef enum logic [1:0] {
    EX_ZERO = 2'd0,
    EX_TOP  = 2'd1,
    EX_DIV  = 2'd2
  } expr_case_e;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV  = 2'd1,
    BK_EMIT = 2'd2
  } bk_state_e;

  // Zone flags of one word, worked out by the front end.
  typedef struct packed {
    logic             single;
    logic             x_gt_left;
    logic             x_lt_left;
    logic             in_band;
    logic             strike;
    logic [BTN_W-1:0] strike_btn;
    expr_case_e       expr_case;
  } cls_t;

  localparam int unsigned CLS_W = $bits(cls_t);

endpackage

>>> hw/rtl/tpz_if.sv
// Valid/ready channel interfaces for reports in and events out.
interface tpz_in_if #(
  parameter int unsigned COORD_WIDTH = 10
) ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             object_count;
  logic [COORD_WIDTH-1:0] centroid_x;
  logic [COORD_WIDTH-1:0] centroid_y;

  modport source (output valid, object_count, centroid_x, centroid_y, input ready);
  modport sink   (input valid, object_count, centroid_x, centroid_y, output ready);
endinterface

interface tpz_out_if ();
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [2:0] button_number;
  logic [7:0] expression_level;
  logic [2:0] tracker_state;

  modport source (output valid, event_kind, button_number, expression_level, tracker_state,
                  input ready);
  modport sink   (input valid, event_kind, button_number, expression_level, tracker_state,
                  output ready);
endinterface

>>> hw/rtl/tpz_front.sv
// Front end: accept reports and classify the point against the zones.
module tpz_front #(
  parameter int unsigned COORD_WIDTH = 10,
  parameter int unsigned LEFT_W      = 10
) (
  tpz_in_if.sink                 in_i,
  input  logic [LEFT_W-1:0]      left_i,
  input  logic [2*COORD_WIDTH-1:0] btn_rows_i,
  input  logic [2*COORD_WIDTH-1:0] expr_rows_i,
  input  logic [4*COORD_WIDTH-1:0] lower_cols_i,
  input  logic [3*COORD_WIDTH-1:0] upper_cols_i,
  input  logic                   full_i,
  output logic                   push_o,
  output tpz_pkg::cls_t          cls_o,
  output logic [COORD_WIDTH-1:0] y_diff_o,
  output logic [COORD_WIDTH-1:0] span_o
);
  import tpz_pkg::*;

  localparam int unsigned C = COORD_WIDTH;

  logic [C-1:0]      x, y, btop, bbot, etop, ebot;
  logic [LEFT_W-1:0] x_ext;
  logic              below, above;
  logic [BTN_W-1:0]  lower_btn, upper_btn;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    x     = in_i.centroid_x;
    y     = in_i.centroid_y;
    x_ext = LEFT_W'(x);
    btop  = btn_rows_i[C-1:0];
    bbot  = btn_rows_i[2*C-1:C];
    etop  = expr_rows_i[C-1:0];
    ebot  = expr_rows_i[2*C-1:C];

    below = y > bbot;
    above = y < btop;

    // First right edge that x lies below wins; scan from the top so the lowest sticks.
    lower_btn = BTN_NONE;
    for (int k = 3; k >= 0; k--) begin
      if (x < lower_cols_i[k*C +: C]) begin
        lower_btn = BTN_W'(k + 1);
      end
    end

    if (x < upper_cols_i[C-1:0]) begin
      upper_btn = BTN_FIVE;
    end else if (x > upper_cols_i[2*C-1:C] && x < upper_cols_i[3*C-1:2*C]) begin
      upper_btn = BTN_SIX;
    end else begin
      upper_btn = BTN_NONE;
    end

    cls_o.single     = in_i.object_count == 2'd1;
    cls_o.x_gt_left  = x_ext > left_i;
    cls_o.x_lt_left  = x_ext < left_i;
    cls_o.in_band    = (y > btop) && (y < bbot);
    cls_o.strike     = below || above;
    cls_o.strike_btn = below ? lower_btn : (above ? upper_btn : BTN_NONE);

    if (y > ebot) begin
      cls_o.expr_case = EX_ZERO;
    end else if (y < etop || ebot == etop) begin
      cls_o.expr_case = EX_TOP;
    end else begin
      cls_o.expr_case = EX_DIV;
    end

    y_diff_o = ebot - y;
    span_o   = ebot - etop;
  end

endmodule

>>> hw/rtl/tpz_queue.sv
// Two-entry queue between the front end and the back end.
module tpz_queue #(
  parameter int unsigned WIDTH = 30
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);
  import tpz_pkg::*;

  `include "assert_macros.svh"

  logic [WIDTH-1:0]   mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wptr_q, rptr_q;
  logic [Q_PTR_W:0]   count_q, count_d;

  assign full_o  = count_q == (Q_PTR_W+1)'(Q_DEPTH);
  assign empty_o = count_q == '0;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  `ASSERT_RST(a_no_push_full, clk_i, rst_ni, push_i |-> !full_o, "push into full queue")
  `ASSERT_RST(a_no_pop_empty, clk_i, rst_ni, pop_i |-> !empty_o, "pop from empty queue")
  `ASSERT_RST(a_count_bound, clk_i, rst_ni, count_q <= (Q_PTR_W+1)'(Q_DEPTH), "queue overfilled")

endmodule

>>> hw/rtl/tpz_div.sv
// Level unit: multiply, then restoring division one quotient bit per cycle.
module tpz_div #(
  parameter int unsigned COORD_WIDTH = 10
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [tpz_pkg::LEVEL_W-1:0] mcand_i,
  input  logic [COORD_WIDTH-1:0]   mplier_i,
  input  logic [COORD_WIDTH-1:0]   dsor_i,
  output logic                     done_o,
  output logic [tpz_pkg::LEVEL_W-1:0] quo_o
);
  import tpz_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned W     = COORD_WIDTH + LEVEL_W;
  localparam int unsigned CNT_W = $clog2(LEVEL_W);

  logic [W-1:0]       prod;
  logic [W-1:0]       rem_q, dsor_q;
  logic [LEVEL_W-1:0] quo_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               busy_q, done_q;
  logic               fits;

  // Quotient stays below 2^LEVEL_W since the numerator is at most top * span.
  assign prod   = W'(mcand_i) * W'(mplier_i);
  assign fits   = rem_q >= dsor_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(LEVEL_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= prod;
      dsor_q <= {1'b0, dsor_i, {(LEVEL_W-1){1'b0}}};
      quo_q  <= '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_q - dsor_q;
      end
      quo_q  <= {quo_q[LEVEL_W-2:0], fits};
      dsor_q <= dsor_q >> 1;
    end
  end

  `ASSERT_RST(a_start_idle, clk_i, rst_ni, start_i |-> !busy_q, "start while busy")
  `ASSERT_RST(a_done_after_busy, clk_i, rst_ni, done_q |-> $past(busy_q), "done without work")

endmodule

>>> hw/rtl/tpz_back.sv
// Back end: tracker state machine, holdoff, level change and the result register.
module tpz_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  input  tpz_pkg::cls_t               head_cls_i,
  input  logic [tpz_pkg::LEVEL_W-1:0] top_level_i,
  input  logic [7:0]                  debounce_i,
  input  logic                        div_done_i,
  input  logic [tpz_pkg::LEVEL_W-1:0] div_quo_i,
  output logic                        pop_o,
  output logic                        div_start_o,
  tpz_out_if.source                   out_o
);
  import tpz_pkg::*;

  `include "assert_macros.svh"

  bk_state_e          state_q, state_d;
  mode_e              mode_q, mode_d;
  logic [7:0]         hold_q, hold_d, hold_dec;
  logic [LEVEL_W-1:0] prev_q, prev_d, lvl_q, lvl_d;
  logic               chk_q, chk_d;
  logic [BTN_W-1:0]   btn_q, btn_d;
  logic               out_valid_q, out_valid_d, load_out;
  logic               level_change;
  ev_kind_e           kind_d;
  logic [1:0]         kind_q;
  logic [BTN_W-1:0]   obtn_q;
  logic [LEVEL_W-1:0] olvl_q;
  logic [2:0]         ostate_q;

  assign out_o.valid            = out_valid_q;
  assign out_o.event_kind       = kind_q;
  assign out_o.button_number    = obtn_q;
  assign out_o.expression_level = olvl_q;
  assign out_o.tracker_state    = ostate_q;

  assign hold_dec     = (hold_q != 8'd0) ? hold_q - 8'd1 : hold_q;
  assign level_change = chk_q && (lvl_q != prev_q);

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    hold_d      = hold_q;
    prev_d      = prev_q;
    lvl_d       = lvl_q;
    chk_d       = chk_q;
    btn_d       = btn_q;
    pop_o       = 1'b0;
    div_start_o = 1'b0;
    load_out    = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;

    if (level_change) begin
      kind_d = EV_LEVEL;
    end else if (btn_q != BTN_NONE) begin
      kind_d = EV_BUTTON;
    end else begin
      kind_d = EV_NONE;
    end

    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          hold_d  = hold_dec;
          chk_d   = 1'b0;
          btn_d   = BTN_NONE;
          lvl_d   = '0;
          state_d = BK_EMIT;
          if (!head_cls_i.single) begin
            if (mode_q != MD_DEBOUNCE) begin
              mode_d = MD_NONE;
            end
          end else begin
            case (mode_q)
              MD_NONE, MD_UNARMED: begin
                if (head_cls_i.x_gt_left) begin
                  mode_d = MD_EXPR;
                end else if (head_cls_i.in_band) begin
                  mode_d = MD_ARMED;
                end else begin
                  mode_d = MD_UNARMED;
                end
              end
              MD_ARMED: begin
                if (head_cls_i.x_gt_left) begin
                  mode_d = MD_EXPR;
                end else if (head_cls_i.strike) begin
                  // A strike outside every button still holds off.
                  mode_d = MD_DEBOUNCE;
                  hold_d = debounce_i;
                  btn_d  = head_cls_i.strike_btn;
                end
              end
              MD_DEBOUNCE: begin
                if (hold_dec == 8'd0) begin
                  mode_d = MD_UNARMED;
                end
              end
              MD_EXPR: begin
                if (head_cls_i.x_lt_left) begin
                  mode_d = MD_UNARMED;
                end else begin
                  chk_d = 1'b1;
                  case (head_cls_i.expr_case)
                    EX_ZERO: lvl_d = '0;
                    EX_TOP:  lvl_d = top_level_i;
                    default: begin
                      div_start_o = 1'b1;
                      state_d     = BK_DIV;
                    end
                  endcase
                end
              end
              default: mode_d = MD_NONE;
            endcase
          end
        end
      end
      BK_DIV: begin
        if (div_done_i) begin
          lvl_d   = div_quo_i;
          state_d = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = BK_IDLE;
          if (level_change) begin
            prev_d = lvl_q;
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      mode_q      <= MD_NONE;
      hold_q      <= '0;
      prev_q      <= '0;
      lvl_q       <= '0;
      chk_q       <= 1'b0;
      btn_q       <= BTN_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      hold_q      <= hold_d;
      prev_q      <= prev_d;
      lvl_q       <= lvl_d;
      chk_q       <= chk_d;
      btn_q       <= btn_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      kind_q   <= kind_d;
      obtn_q   <= (kind_d == EV_BUTTON) ? btn_q : BTN_NONE;
      olvl_q   <= (kind_d == EV_LEVEL) ? lvl_q : '0;
      ostate_q <= mode_q;
    end
  end

  `ASSERT_RST(a_done_in_div, clk_i, rst_ni, div_done_i |-> (state_q == BK_DIV),
              "level unit finished outside the divide wait")
  `ASSERT_RST(a_button_debounce, clk_i, rst_ni,
              (out_valid_q && kind_q == EV_BUTTON) |-> (ostate_q == MD_DEBOUNCE),
              "button event without holdoff")

endmodule

>>> hw/rtl/tracked_point_zone_trigger_unit.sv
// Top level of the tracked-point zone trigger.
//
// Usage: in_i takes one report word per video frame (object count, centroid x and y);
// out_o gives one event word per report (event kind, button, expression level and
// the tracker mode after that report). Both are valid/ready channels.
// Configuration goes through cfg_we_i / cfg_idx_i / cfg_wdata_i, one register per
// write, only while no report is in flight. Indexes past the last register are dropped.
//
// Flow: an accepted word goes into the queue; the back end pops it, then loads the
// result register in its emit state. An expression level that falls between the
// expression rows first runs through the multiply/divide unit (a product, then 8
// quotient bits, then the back end takes the quotient). The back end handles one word
// at a time: it pops no new word until the last one is in the output register.
// The front end keeps accepting into a two-word queue while the back end works, and
// a finished word sits in the output register while the next one is processed.
// When the receiver stalls, the output register holds, then the back end, then the
// queue fills and in_i.ready drops.
// Reset: control and configuration registers go to their reset values, tracker to no
// track, holdoff and last level to zero; no clearing pass of data registers is needed.
module tracked_point_zone_trigger_unit #(
  parameter int unsigned COORD_WIDTH = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  tpz_in_if.sink                              in_i,
  tpz_out_if.source                           out_o,
  input  logic                                cfg_we_i,
  input  logic [tpz_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [4*COORD_WIDTH-1:0]            cfg_wdata_i
);
  import tpz_pkg::*;

  localparam int unsigned C      = COORD_WIDTH;
  // Wide enough for the reset edge of the expression zone at any coordinate width.
  localparam int unsigned LEFT_W = (COORD_WIDTH > 9) ? COORD_WIDTH : 9;
  localparam int unsigned QW     = CLS_W + 2 * COORD_WIDTH;

  // Configuration registers.
  logic [7:0]        divisions_q;
  logic [7:0]        debounce_q;
  logic [LEFT_W-1:0] left_q;
  logic [2*C-1:0]    btn_rows_q;
  logic [2*C-1:0]    expr_rows_q;
  logic [4*C-1:0]    lower_cols_q;
  logic [3*C-1:0]    upper_cols_q;
  logic [7:0]        top_level;

  // Front to queue.
  logic              push, full;
  cls_t              cls;
  logic [C-1:0]      y_diff, span;
  logic [QW-1:0]     push_word, head_word;

  // Queue to back end.
  logic              pop, empty;
  cls_t              head_cls;
  logic [C-1:0]      head_ydiff, head_span;

  // Level unit handshake.
  logic              div_start, div_done;
  logic [LEVEL_W-1:0] div_quo;

  // Highest level; zero divisions wrap to all ones.
  assign top_level = divisions_q - 8'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divisions_q  <= 8'd128;
      debounce_q   <= 8'd15;
      left_q       <= LEFT_W'(480);
      btn_rows_q   <= '0;
      expr_rows_q  <= '0;
      lower_cols_q <= '0;
      upper_cols_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DIVISIONS:  divisions_q  <= cfg_wdata_i[7:0];
        CFG_DEBOUNCE:   debounce_q   <= cfg_wdata_i[7:0];
        CFG_LEFT_X:     left_q       <= LEFT_W'(cfg_wdata_i[C-1:0]);
        CFG_BTN_ROWS:   btn_rows_q   <= cfg_wdata_i[2*C-1:0];
        CFG_EXPR_ROWS:  expr_rows_q  <= cfg_wdata_i[2*C-1:0];
        CFG_LOWER_COLS: lower_cols_q <= cfg_wdata_i[4*C-1:0];
        CFG_UPPER_COLS: upper_cols_q <= cfg_wdata_i[3*C-1:0];
        default: ;
      endcase
    end
  end

  // Accept and classify.
  tpz_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .LEFT_W      (LEFT_W)
  ) u_front (
    .in_i         (in_i),
    .left_i       (left_q),
    .btn_rows_i   (btn_rows_q),
    .expr_rows_i  (expr_rows_q),
    .lower_cols_i (lower_cols_q),
    .upper_cols_i (upper_cols_q),
    .full_i       (full),
    .push_o       (push),
    .cls_o        (cls),
    .y_diff_o     (y_diff),
    .span_o       (span)
  );

  assign push_word = {cls, y_diff, span};

  // Decouple front and back.
  tpz_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_word),
    .pop_i   (pop),
    .rdata_o (head_word),
    .full_o  (full),
    .empty_o (empty)
  );

  assign head_cls   = cls_t'(head_word[QW-1 -: CLS_W]);
  assign head_ydiff = head_word[2*C-1:C];
  assign head_span  = head_word[C-1:0];

  // Level = top * (bottom - y) / (bottom - top_row), started as the word is popped.
  tpz_div #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .mcand_i  (top_level),
    .mplier_i (head_ydiff),
    .dsor_i   (head_span),
    .done_o   (div_done),
    .quo_o    (div_quo)
  );

  // Tracker, holdoff and result register.
  tpz_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_cls_i  (head_cls),
    .top_level_i (top_level),
    .debounce_i  (debounce_q),
    .div_done_i  (div_done),
    .div_quo_i   (div_quo),
    .pop_o       (pop),
    .div_start_o (div_start),
    .out_o       (out_o)
  );

endmodule

>>> bench/tb_tracked_point_zone_trigger_unit.sv
// Self-checking testbench of the tracked-point zone trigger: directed tables, then random phases.
`timescale 1ns / 1ps

module tb_tracked_point_zone_trigger_unit;
  import tpz_pkg::*;

  localparam int unsigned CW          = 10;
  localparam int unsigned CFG_W       = 4 * CW;
  localparam int unsigned CLK_PERIOD  = 8;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_WORDS = 192;
  localparam int unsigned TAIL_CYCLES = 16;
  localparam int unsigned TIMEOUT_NS  = 4_000_000;

  typedef logic [CW-1:0] coord_t;

  typedef struct packed {
    ev_kind_e               kind;
    logic [BTN_W-1:0]       button;
    logic [LEVEL_W-1:0]     level;
    mode_e                  mode;
  } event_word_t;

  typedef struct packed {
    logic [1:0]  count;
    coord_t      x;
    coord_t      y;
    logic        typed;
    event_word_t ev;
  } report_row_t;

  localparam event_word_t UNTYPED = '0;

  // Reset configuration: left edge 480, every row and column at zero, 128 divisions.
  // The expected event of each row is written out by hand.
  localparam report_row_t RESET_ROWS [9] = '{
    '{2'd0, 10'd0,    10'd0,    1'b1, '{EV_NONE,  BTN_NONE, 8'd0,   MD_NONE}},
    '{2'd3, 10'd1023, 10'd1023, 1'b1, '{EV_NONE,  BTN_NONE, 8'd0,   MD_NONE}},
    '{2'd1, 10'd0,    10'd0,    1'b1, '{EV_NONE,  BTN_NONE, 8'd0,   MD_UNARMED}},
    '{2'd1, 10'd1023, 10'd1023, 1'b1, '{EV_NONE,  BTN_NONE, 8'd0,   MD_EXPR}},
    '{2'd1, 10'd1023, 10'd1023, 1'b1, '{EV_NONE,  BTN_NONE, 8'd0,   MD_EXPR}},
    // flat expression rows: top level, 127 here
    '{2'd1, 10'd481,  10'd0,    1'b1, '{EV_LEVEL, BTN_NONE, 8'd127, MD_EXPR}},
    // x on the left edge keeps the zone
    '{2'd1, 10'd480,  10'd0,    1'b1, '{EV_NONE,  BTN_NONE, 8'd0,   MD_EXPR}},
    '{2'd1, 10'd479,  10'd5,    1'b1, '{EV_NONE,  BTN_NONE, 8'd0,   MD_UNARMED}},
    '{2'd2, 10'd0,    10'd0,    1'b1, '{EV_NONE,  BTN_NONE, 8'd0,   MD_NONE}}
  };

  // Lab configuration: band 200..400, expression 100..900 right of 600, nine divisions,
  // lower edges 100/200/300/400, button five below 150, button six in 250..350.
  localparam report_row_t LAB_ROWS [17] = '{
    '{2'd1, 10'd50,   10'd300,  1'b0, UNTYPED},  // arm
    '{2'd1, 10'd50,   10'd500,  1'b0, UNTYPED},  // lower strike, button one
    '{2'd0, 10'd0,    10'd0,    1'b0, UNTYPED},  // lost object while holding off
    '{2'd1, 10'd0,    10'd0,    1'b0, UNTYPED},
    '{2'd1, 10'd0,    10'd0,    1'b0, UNTYPED},  // holdoff expires
    '{2'd1, 10'd390,  10'd300,  1'b0, UNTYPED},
    '{2'd1, 10'd450,  10'd100,  1'b0, UNTYPED},  // upper strike outside every button
    '{2'd2, 10'd0,    10'd0,    1'b0, UNTYPED},
    '{2'd3, 10'd1023, 10'd1023, 1'b0, UNTYPED},
    '{2'd1, 10'd0,    10'd0,    1'b0, UNTYPED},
    '{2'd1, 10'd300,  10'd399,  1'b0, UNTYPED},
    '{2'd1, 10'd601,  10'd500,  1'b0, UNTYPED},  // armed into expression, no level yet
    '{2'd1, 10'd700,  10'd500,  1'b0, UNTYPED},  // divided level
    '{2'd1, 10'd700,  10'd1000, 1'b0, UNTYPED},  // below the zone: level zero
    '{2'd1, 10'd599,  10'd0,    1'b0, UNTYPED},
    '{2'd1, 10'd100,  10'd250,  1'b0, UNTYPED},
    '{2'd1, 10'd100,  10'd199,  1'b0, UNTYPED}   // upper strike, button five
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  tpz_in_if #(.COORD_WIDTH(CW)) report_ch ();
  tpz_out_if                    event_ch ();

  tracked_point_zone_trigger_unit #(
    .COORD_WIDTH(CW)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (report_ch),
    .out_o       (event_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Mirror of the block's registers and tracker, starting from the reset values.
  logic [7:0]      divisions  = 8'd128;
  logic [7:0]      debounce   = 8'd15;
  coord_t          left_x     = 10'd480;
  logic [2*CW-1:0] band_rows  = '0;
  logic [2*CW-1:0] zone_rows  = '0;
  logic [4*CW-1:0] lower_cols = '0;
  logic [3*CW-1:0] upper_cols = '0;
  mode_e           tracker    = MD_NONE;
  logic [7:0]      holdoff    = 8'd0;
  logic [7:0]      last_level = 8'd0;

  event_word_t     pending_events [$];
  int unsigned     mismatches = 0;
  int unsigned     burst_left = 0;

  // Advance the tracker by one report and return the event word it gives.
  function automatic event_word_t predict_event(logic [1:0] cnt, coord_t x, coord_t y);
    event_word_t ev;
    coord_t      bt, bb, et, eb;
    logic [7:0]  topl;
    int unsigned num, den, lvl, k;
    ev   = '{EV_NONE, BTN_NONE, 8'd0, MD_NONE};
    bt   = band_rows[CW-1:0];
    bb   = band_rows[2*CW-1:CW];
    et   = zone_rows[CW-1:0];
    eb   = zone_rows[2*CW-1:CW];
    topl = divisions - 8'd1;  // zero divisions wrap to 255
    if (holdoff != 8'd0) holdoff = holdoff - 8'd1;
    if (cnt != 2'd1) begin
      if (tracker != MD_DEBOUNCE) tracker = MD_NONE;
    end else begin
      case (tracker)
        MD_NONE, MD_UNARMED: begin
          if (x > left_x) tracker = MD_EXPR;
          else if (y > bt && y < bb) tracker = MD_ARMED;
          else tracker = MD_UNARMED;
        end
        MD_ARMED: begin
          if (x > left_x) begin
            tracker = MD_EXPR;
          end else if (y > bb) begin
            tracker = MD_DEBOUNCE;
            holdoff = debounce;
            for (k = 0; k < 4; k++) begin
              if (ev.button == BTN_NONE && x < lower_cols[k*CW +: CW]) ev.button = BTN_W'(k + 1);
            end
          end else if (y < bt) begin
            tracker = MD_DEBOUNCE;
            holdoff = debounce;
            if (x < upper_cols[CW-1:0]) ev.button = BTN_FIVE;
            else if (x > upper_cols[2*CW-1:CW] && x < upper_cols[3*CW-1:2*CW])
              ev.button = BTN_SIX;
          end
          if (ev.button != BTN_NONE) ev.kind = EV_BUTTON;
        end
        MD_DEBOUNCE: begin
          if (holdoff == 8'd0) tracker = MD_UNARMED;
        end
        MD_EXPR: begin
          if (x < left_x) begin
            tracker = MD_UNARMED;
          end else begin
            if (y > eb) begin
              lvl = 0;
            end else if (y < et || eb == et) begin
              lvl = topl;
            end else begin
              // here et <= y <= eb and et != eb, so the divisor is positive and the numerator not negative
              num = topl;
              num = num * (eb - y);
              den = eb - et;
              lvl = num / den;
            end
            if (lvl[7:0] != last_level) begin
              last_level = lvl[7:0];
              ev.kind    = EV_LEVEL;
              ev.level   = lvl[7:0];
            end
          end
        end
        default: tracker = MD_NONE;
      endcase
    end
    ev.mode = tracker;
    return ev;
  endfunction

  // A coordinate one below, on or one above an edge; wraps at the ends of the range.
  function automatic coord_t near(coord_t pos);
    return pos + coord_t'($urandom_range(0, 2)) - coord_t'(1);
  endfunction

  // Build a report that steers the tracker on from where it stands, with some noise.
  task automatic make_report(output logic [1:0] cnt, output coord_t x, output coord_t y);
    coord_t      bt, bb, et, eb;
    int unsigned pick;
    bt   = band_rows[CW-1:0];
    bb   = band_rows[2*CW-1:CW];
    et   = zone_rows[CW-1:0];
    eb   = zone_rows[2*CW-1:CW];
    pick = $urandom_range(0, 99);
    cnt  = ($urandom_range(0, 11) == 0) ? 2'($urandom_range(0, 3)) : 2'd1;
    x    = coord_t'($urandom);
    y    = coord_t'($urandom);
    if (pick < 15) return;
    case (tracker)
      MD_NONE, MD_UNARMED: begin
        if (pick < 75) begin
          x = coord_t'($urandom_range(0, left_x));
          y = (bb > bt + 1) ? coord_t'($urandom_range(bt + 1, bb - 1)) : near(bt);
        end else begin
          x = ($urandom_range(0, 1) == 0) ? near(left_x) : coord_t'($urandom_range(left_x, 1023));
        end
      end
      MD_ARMED: begin
        if (pick < 55) begin
          y = ($urandom_range(0, 1) == 0) ? near(bb) : coord_t'($urandom_range(bb, 1023));
          x = near(lower_cols[$urandom_range(0, 3)*CW +: CW]);
        end else if (pick < 85) begin
          y = ($urandom_range(0, 1) == 0) ? near(bt) : coord_t'($urandom_range(0, bt));
          x = near(upper_cols[$urandom_range(0, 2)*CW +: CW]);
        end else if (pick < 93) begin
          x = coord_t'($urandom_range(0, left_x));
          y = coord_t'($urandom_range(bt, bb));
        end else begin
          x = near(left_x);
        end
      end
      MD_EXPR: begin
        if (pick < 85) begin
          x = ($urandom_range(0, 1) == 0) ? near(left_x) : coord_t'($urandom_range(left_x, 1023));
          case ($urandom_range(0, 3))
            0:       y = near(et);
            1:       y = near(eb);
            2:       y = coord_t'($urandom_range(et, eb));
            default: ;
          endcase
        end else begin
          x = coord_t'($urandom_range(0, left_x));
        end
      end
      default: ;
    endcase
  endtask

  // Offer one report word in bursts with random gaps; predict it once it is taken.
  task automatic send_report(logic [1:0] cnt, coord_t x, coord_t y, logic typed,
                             event_word_t typed_ev);
    int unsigned gap;
    event_word_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk_i);
        report_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    report_ch.valid        <= 1'b1;
    report_ch.object_count <= cnt;
    report_ch.centroid_x   <= x;
    report_ch.centroid_y   <= y;
    do @(posedge clk_i); while (!report_ch.ready);
    predicted = predict_event(cnt, x, y);
    pending_events.push_back(typed ? typed_ev : predicted);
  endtask

  // Drop valid and hold until every expected event word has come back.
  task automatic wait_for_drain();
    @(negedge clk_i);
    report_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_events.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_DIVISIONS:  divisions  = val[7:0];
      CFG_DEBOUNCE:   debounce   = val[7:0];
      CFG_LEFT_X:     left_x     = val[CW-1:0];
      CFG_BTN_ROWS:   band_rows  = val[2*CW-1:0];
      CFG_EXPR_ROWS:  zone_rows  = val[2*CW-1:0];
      CFG_LOWER_COLS: lower_cols = val;
      CFG_UPPER_COLS: upper_cols = val[3*CW-1:0];
      default: ;
    endcase
  endtask

  // Load every register, back to back; only called with nothing in flight.
  task automatic program_zones(logic [7:0] div_v, logic [7:0] deb_v, coord_t left_v,
                               coord_t bt, coord_t bb, coord_t et, coord_t eb,
                               logic [4*CW-1:0] lcols, logic [3*CW-1:0] ucols);
    write_reg(CFG_DIVISIONS,  CFG_W'(div_v));
    write_reg(CFG_DEBOUNCE,   CFG_W'(deb_v));
    write_reg(CFG_LEFT_X,     CFG_W'(left_v));
    write_reg(CFG_BTN_ROWS,   CFG_W'({bb, bt}));
    write_reg(CFG_EXPR_ROWS,  CFG_W'({eb, et}));
    write_reg(CFG_LOWER_COLS, lcols);
    write_reg(CFG_UPPER_COLS, CFG_W'(ucols));
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Each phase draws a fresh layout; some phases pin registers at an extreme or flatten or invert the expression rows.
  task automatic program_random_zones(int unsigned phase);
    logic [7:0] div_v, deb_v;
    coord_t     left_v, bt, bb, et, eb, c0, c1, c2, c3, u0, u1, u2;
    div_v  = (phase == 0) ? 8'd0 : (phase == 1) ? 8'd1 : (phase == 2) ? 8'd255 :
             8'($urandom_range(2, 40));
    deb_v  = (phase == 3) ? 8'd255 : (phase == 4) ? 8'd0 : 8'($urandom_range(1, 6));
    left_v = (phase == 5) ? 10'd0 : (phase == 6) ? 10'd1023 : coord_t'($urandom_range(400, 900));
    bt = coord_t'($urandom_range(150, 450));
    bb = bt + coord_t'($urandom_range(2, 250));
    et = coord_t'($urandom_range(0, 400));
    eb = et + coord_t'($urandom_range(1, 600));
    c0 = coord_t'($urandom_range(20, 250));
    c1 = c0 + coord_t'($urandom_range(0, 150));
    c2 = c1 + coord_t'($urandom_range(0, 150));
    c3 = c2 + coord_t'($urandom_range(0, 150));
    u0 = coord_t'($urandom_range(20, 300));
    u1 = u0 + coord_t'($urandom_range(0, 100));
    u2 = u1 + coord_t'($urandom_range(2, 200));
    case (phase)
      5: begin
        c0 = 10'd0;
        u0 = 10'd0;
      end
      6: begin
        c3 = 10'd1023;
        u2 = 10'd1023;
      end
      7: begin
        // full-height rows: nothing lies beyond the band, so no strike can land
        bt = 10'd0;
        bb = 10'd1023;
        et = 10'd0;
        eb = 10'd1023;
      end
      8: eb = et;                              // flat expression rows
      9: eb = et - coord_t'($urandom_range(1, 40));  // inverted expression rows
      default: ;
    endcase
    program_zones(div_v, deb_v, left_v, bt, bb, et, eb, {c3, c2, c1, c0}, {u2, u1, u0});
  endtask

  // Compare each event word taken off the output with the oldest prediction.
  always @(posedge clk_i) begin
    event_word_t want;
    if (rst_ni && event_ch.valid && event_ch.ready) begin
      if (pending_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected event word: kind %0d button %0d level %0d mode %0d",
                   event_ch.event_kind, event_ch.button_number,
                   event_ch.expression_level, event_ch.tracker_state);
      end else begin
        want = pending_events.pop_front();
        if (event_ch.event_kind !== want.kind || event_ch.button_number !== want.button ||
            event_ch.expression_level !== want.level || event_ch.tracker_state !== want.mode)
        begin
          mismatches++;
          if (mismatches <= 10)
            $display("event mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                     want.kind, want.button, want.level, want.mode,
                     event_ch.event_kind, event_ch.button_number,
                     event_ch.expression_level, event_ch.tracker_state);
        end
      end
    end
  end

  // Stall the event side on a random 16-bit ready pattern, redrawn after a random span;
  // a fully open pattern gives stretches with no stall at all.
  initial begin : receiver
    logic [15:0] pattern;
    int unsigned span, j;
    event_ch.ready = 1'b0;
    forever begin
      span = $urandom_range(16, 96);
      case ($urandom_range(0, 3))
        0:       pattern = '1;
        1:       pattern = 16'($urandom);
        2:       pattern = 16'($urandom | $urandom);
        default: pattern = 16'($urandom & $urandom) | 16'h8001;
      endcase
      for (j = 0; j < span; j++) begin
        @(negedge clk_i);
        event_ch.ready <= pattern[j % 16];
      end
    end
  end

  initial begin : stimulus
    int unsigned i, phase, n;
    logic [1:0]  cnt;
    coord_t      x, y;
    // hold every input at a known value from time zero
    rst_ni                 = 1'b0;
    cfg_we                 = 1'b0;
    cfg_idx                = '0;
    cfg_wdata              = '0;
    report_ch.valid        = 1'b0;
    report_ch.object_count = 2'd0;
    report_ch.centroid_x   = '0;
    report_ch.centroid_y   = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (i = 0; i < $size(RESET_ROWS); i++)
      send_report(RESET_ROWS[i].count, RESET_ROWS[i].x, RESET_ROWS[i].y,
                  RESET_ROWS[i].typed, RESET_ROWS[i].ev);
    wait_for_drain();

    program_zones(8'd9, 8'd3, 10'd600, 10'd200, 10'd400, 10'd100, 10'd900,
                  {10'd400, 10'd300, 10'd200, 10'd100}, {10'd350, 10'd250, 10'd150});
    for (i = 0; i < $size(LAB_ROWS); i++)
      send_report(LAB_ROWS[i].count, LAB_ROWS[i].x, LAB_ROWS[i].y,
                  LAB_ROWS[i].typed, LAB_ROWS[i].ev);
    wait_for_drain();

    for (phase = 0; phase < PHASES; phase++) begin
      program_random_zones(phase);
      for (n = 0; n < PHASE_WORDS; n++) begin
        make_report(cnt, x, y);
        send_report(cnt, x, y, 1'b0, UNTYPED);
        // now and then let the block run completely dry mid-phase
        if ($urandom_range(0, 119) == 0) wait_for_drain();
      end
      wait_for_drain();
    end

    // watch a little longer for stray event words
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("tracked_point_zone_trigger_unit verification clean");
    end else begin
      $display("tracked_point_zone_trigger_unit verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("tracked_point_zone_trigger_unit verification failed");
    $finish;
  end

endmodule
